// ----- src/caf_pkg.sv -----
// Shared types and constants for the add, subtract and compare flags unit.
package caf_pkg;

	// Operation codes on the action port.
	localparam logic [1:0] ACT_ADC = 2'd0;
	localparam logic [1:0] ACT_SBC = 2'd1;
	localparam logic [1:0] ACT_CMP = 2'd2;

	// Bit positions in the processor status byte.
	localparam int unsigned FLAG_C_BIT = 0;
	localparam int unsigned FLAG_Z_BIT = 1;
	localparam int unsigned FLAG_D_BIT = 3;
	localparam int unsigned FLAG_V_BIT = 6;
	localparam int unsigned FLAG_N_BIT = 7;

	// What the last stage does with the adder result.
	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_ARITH,
		KIND_CMP
	} kind_t;

	// Decoded transaction after the first stage.
	typedef struct packed {
		kind_t       kind;
		logic        fault;
		logic        wide;
		logic [15:0] acc;
		logic [7:0]  status;
		logic [15:0] lhs;
		logic [15:0] rhs;
		logic        cin;
	} s1_t;

	// Transaction after the low-byte add.
	typedef struct packed {
		kind_t       kind;
		logic        fault;
		logic        wide;
		logic [15:0] acc;
		logic [7:0]  status;
		logic [7:0]  lhs_hi;
		logic [7:0]  rhs_hi;
		logic        lhs_b7;
		logic        rhs_b7;
		logic [8:0]  sum_lo;
	} s2_t;

	// Finished result.
	typedef struct packed {
		logic [15:0] acc;
		logic [7:0]  status;
		logic        fault;
	} s3_t;

endpackage

// ----- src/caf_prep.sv -----
// Decode stage: selects operands, inverts the right side for subtraction and picks carry in.
module caf_prep (
	input  logic [1:0]   action,
	input  logic         wide,
	input  logic [15:0]  acc_in,
	input  logic [7:0]   status_in,
	input  logic [15:0]  compare_left,
	input  logic [15:0]  operand,
	output caf_pkg::s1_t dec
);

	// Subtraction and compare are done as lhs + ~rhs + carry.
	always_comb begin
		dec.kind   = caf_pkg::KIND_PASS;
		dec.fault  = 1'b0;
		dec.wide   = wide;
		dec.acc    = acc_in;
		dec.status = status_in;
		dec.lhs    = acc_in;
		dec.rhs    = operand;
		dec.cin    = status_in[caf_pkg::FLAG_C_BIT];
		case (action)
			caf_pkg::ACT_ADC, caf_pkg::ACT_SBC: begin
				if (status_in[caf_pkg::FLAG_D_BIT]) begin
					dec.fault = 1'b1;
				end else begin
					dec.kind = caf_pkg::KIND_ARITH;
				end
				if (action == caf_pkg::ACT_SBC) begin
					dec.rhs = ~operand;
				end
			end
			caf_pkg::ACT_CMP: begin
				dec.kind = caf_pkg::KIND_CMP;
				dec.lhs  = compare_left;
				dec.rhs  = ~operand;
				dec.cin  = 1'b1;
			end
			default: begin
				dec.kind = caf_pkg::KIND_PASS;
			end
		endcase
	end

endmodule

// ----- src/caf_lo_add.sv -----
// Second stage logic: adds the low bytes and forwards the high bytes.
module caf_lo_add (
	input  caf_pkg::s1_t d,
	output caf_pkg::s2_t q
);

	// The low-byte carry out feeds the high-byte add in the next stage.
	always_comb begin
		q.kind   = d.kind;
		q.fault  = d.fault;
		q.wide   = d.wide;
		q.acc    = d.acc;
		q.status = d.status;
		q.lhs_hi = d.lhs[15:8];
		q.rhs_hi = d.rhs[15:8];
		q.lhs_b7 = d.lhs[7];
		q.rhs_b7 = d.rhs[7];
		q.sum_lo = {1'b0, d.lhs[7:0]} + {1'b0, d.rhs[7:0]} + {8'd0, d.cin};
	end

endmodule

// ----- src/caf_hi_flags.sv -----
// Third stage logic: adds the high bytes, forms the flags and assembles the result.
module caf_hi_flags (
	input  caf_pkg::s2_t d,
	output caf_pkg::s3_t q
);

	logic [8:0]  sum_hi;
	logic [15:0] res;
	logic        c_f;
	logic        v_f;
	logic        n_f;
	logic        z_f;
	logic [7:0]  st;

	// High-byte add and flags for the selected width.
	always_comb begin
		sum_hi = {1'b0, d.lhs_hi} + {1'b0, d.rhs_hi} + {8'd0, d.sum_lo[8]};
		res    = {sum_hi[7:0], d.sum_lo[7:0]};
		if (d.wide) begin
			c_f = sum_hi[8];
			n_f = res[15];
			z_f = (res == 16'd0);
			v_f = ~(d.lhs_hi[7] ^ d.rhs_hi[7]) & (d.lhs_hi[7] ^ res[15]);
		end else begin
			c_f = d.sum_lo[8];
			n_f = res[7];
			z_f = (res[7:0] == 8'd0);
			v_f = ~(d.lhs_b7 ^ d.rhs_b7) & (d.lhs_b7 ^ res[7]);
		end
	end

	// Result assembly: compare leaves the accumulator and V alone.
	always_comb begin
		st      = d.status;
		q.acc   = d.acc;
		q.fault = d.fault;
		case (d.kind)
			caf_pkg::KIND_ARITH: begin
				st[caf_pkg::FLAG_C_BIT] = c_f;
				st[caf_pkg::FLAG_V_BIT] = v_f;
				st[caf_pkg::FLAG_N_BIT] = n_f;
				st[caf_pkg::FLAG_Z_BIT] = z_f;
				q.acc = d.wide ? res : {d.acc[15:8], res[7:0]};
			end
			caf_pkg::KIND_CMP: begin
				st[caf_pkg::FLAG_C_BIT] = c_f;
				st[caf_pkg::FLAG_N_BIT] = n_f;
				st[caf_pkg::FLAG_Z_BIT] = z_f;
			end
			default: begin
				st = d.status;
			end
		endcase
		q.status = st;
	end

endmodule

// ----- src/cpu_alu_add_sub_compare_flags_unit.sv -----
// Top level: three-stage binary add, subtract and compare unit with status flags.
// A transaction accepted at a clock edge moves through the register stages in order, and
// the last one drives the result outputs. The three register stages are decode, low-byte
// add, and high-byte add with flag forming. A new transaction can be accepted every cycle
// while in_stall is low. A stall on the output holds the pipeline, and in_stall rises
// only when every stage is full and the finished result is not taken.
// Add and subtract with the decimal flag set return the inputs unchanged with
// decimal_fault high; action code 3 passes the accumulator and status through.
module cpu_alu_add_sub_compare_flags_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic        wide,
	input  logic [15:0] acc_in,
	input  logic [7:0]  status_in,
	input  logic [15:0] compare_left,
	input  logic [15:0] operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] acc_out,
	output logic [7:0]  status_out,
	output logic        decimal_fault
);

	caf_pkg::s1_t dec;
	caf_pkg::s2_t lo;
	caf_pkg::s3_t hi;
	caf_pkg::s1_t d_s1;
	caf_pkg::s2_t d_s2;
	caf_pkg::s3_t d_s3;
	logic         v_s1;
	logic         v_s2;
	logic         v_s3;
	logic         rdy1;
	logic         rdy2;
	logic         rdy3;

	caf_prep u_prep (
		.action       (action),
		.wide         (wide),
		.acc_in       (acc_in),
		.status_in    (status_in),
		.compare_left (compare_left),
		.operand      (operand),
		.dec          (dec)
	);

	caf_lo_add u_lo_add (
		.d (d_s1),
		.q (lo)
	);

	caf_hi_flags u_hi_flags (
		.d (d_s2),
		.q (hi)
	);

	// A stage may load when it is empty or its content moves on.
	assign rdy3     = !v_s3 || !out_stall;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Payload registers load only when their stage advances.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			d_s1 <= dec;
		end
		if (rdy2) begin
			d_s2 <= lo;
		end
		if (rdy3) begin
			d_s3 <= hi;
		end
	end

	assign out_valid     = v_s3;
	assign acc_out       = d_s3.acc;
	assign status_out    = d_s3.status;
	assign decimal_fault = d_s3.fault;

	// A fault is only raised when the decimal flag was set, and status passes through.
	a_fault_has_d: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && decimal_fault |-> status_out[caf_pkg::FLAG_D_BIT])
		else $error("decimal fault without the decimal flag");

	// An accepted transaction occupies the first stage on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transaction lost at the first stage");

	// A blocked first stage keeps its transaction.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy2 |=> v_s1 && $stable(d_s1))
		else $error("first stage changed while blocked");

endmodule
